// File: hw/rtl/gpet_pkg.sv
package gpet_pkg;

	localparam int MAX_LINE_DEF = 1024;

	localparam int PIX_W   = 8;
	localparam int THR_W   = 10;
	localparam int CFG_W   = 11;
	localparam int SUM_W   = 11;
	localparam int ROW_W   = PIX_W + 2;
	localparam int RECIP_W = 10;

	// floor(s / 3) for s up to 765 equals (s * 683) >> 11.
	localparam logic [RECIP_W-1:0] GRAY_RECIP = 10'd683;
	localparam int GRAY_SHIFT = 11;

	localparam int SIZE_MIN     = 3;
	localparam int INTERIOR_MIN = 2;

	localparam logic [THR_W-1:0] THR_RESET    = 10'd20;
	localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd800;
	localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;

	localparam logic [PIX_W-1:0] EDGE_ON  = 8'd255;
	localparam logic [PIX_W-1:0] EDGE_OFF = 8'd0;

	typedef enum logic [1:0] {
		CFG_EDGE_THRESHOLD = 2'd0,
		CFG_LINE_PIXELS    = 2'd1,
		CFG_FRAME_LINES    = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic load;
		logic write;
	} lb_ctl_t;

endpackage

// File: hw/rtl/gpet_pos.sv
module gpet_pos import gpet_pkg::*; #(
	parameter int MAX_LINE = MAX_LINE_DEF,
	localparam int CW = $clog2(MAX_LINE)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  logic             frame_start,
	input  logic [CFG_W-1:0] line_pixels,
	input  logic [CFG_W-1:0] frame_lines,
	output logic [CW-1:0]    col,
	output logic             interior
);

	localparam int LW    = $clog2(MAX_LINE + 1);
	localparam int CMP_W = (LW > CFG_W) ? LW : CFG_W;

	logic [CW-1:0]    col_q, row_q;
	logic [CW-1:0]    col_cur, row_cur, col_nxt, row_nxt;
	logic [LW-1:0]    col_inc, row_inc;
	logic [LW-1:0]    w_eff, h_eff;
	logic [CMP_W-1:0] w_raw, h_raw;

	always_comb begin
		w_raw = CMP_W'(line_pixels);
		h_raw = CMP_W'(frame_lines);
		if (w_raw < CMP_W'(SIZE_MIN)) begin
			w_eff = LW'(SIZE_MIN);
		end else if (w_raw > CMP_W'(MAX_LINE)) begin
			w_eff = LW'(MAX_LINE);
		end else begin
			w_eff = LW'(w_raw);
		end
		if (h_raw < CMP_W'(SIZE_MIN)) begin
			h_eff = LW'(SIZE_MIN);
		end else if (h_raw > CMP_W'(MAX_LINE)) begin
			h_eff = LW'(MAX_LINE);
		end else begin
			h_eff = LW'(h_raw);
		end
	end

	always_comb begin
		col_cur = col_q;
		row_cur = row_q;
		if (frame_start) begin
			col_cur = '0;
			row_cur = '0;
		end
		// A size that shrank since the count was stored restarts the position.
		if (LW'(col_cur) >= w_eff) begin
			col_cur = '0;
		end
		if (LW'(row_cur) >= h_eff) begin
			row_cur = '0;
		end
		col_inc = LW'(col_cur) + LW'(1);
		row_inc = LW'(row_cur) + LW'(1);
		if (col_inc == w_eff) begin
			col_nxt = '0;
			row_nxt = (row_inc == h_eff) ? '0 : CW'(row_inc);
		end else begin
			col_nxt = CW'(col_inc);
			row_nxt = row_cur;
		end
	end

	assign col      = col_cur;
	assign interior = (row_cur >= CW'(INTERIOR_MIN)) && (col_cur >= CW'(INTERIOR_MIN));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (load) begin
			col_q <= col_nxt;
			row_q <= row_nxt;
		end
	end

endmodule

// File: hw/rtl/gpet_linebuf.sv
module gpet_linebuf import gpet_pkg::*; #(
	parameter int MAX_LINE = MAX_LINE_DEF,
	localparam int AW = $clog2(MAX_LINE)
) (
	input  logic             clk,
	input  lb_ctl_t          ctl,
	input  logic [AW-1:0]    rd_addr,
	input  logic [AW-1:0]    wr_addr,
	input  logic [PIX_W-1:0] wr_gray,
	output logic [PIX_W-1:0] upper_s1,
	output logic [PIX_W-1:0] middle_s1
);

	logic [PIX_W-1:0] upper_mem  [MAX_LINE];
	logic [PIX_W-1:0] middle_mem [MAX_LINE];
	logic             fwd;

	// Only a frame restart on column zero can read the entry written in the same cycle.
	assign fwd = ctl.write && (wr_addr == rd_addr);

	always_ff @(posedge clk) begin
		if (ctl.write) begin
			upper_mem[wr_addr]  <= middle_s1;
			middle_mem[wr_addr] <= wr_gray;
		end
		if (ctl.load) begin
			upper_s1  <= fwd ? middle_s1 : upper_mem[rd_addr];
			middle_s1 <= fwd ? wr_gray : middle_mem[rd_addr];
		end
	end

endmodule

// File: hw/rtl/gpet_kernel.sv
module gpet_kernel import gpet_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  logic                    interior,
	input  logic [PIX_W-1:0]        top_pix,
	input  logic [PIX_W-1:0]        gray,
	input  logic [THR_W-1:0]        threshold,
	output logic signed [SUM_W-1:0] sum,
	output logic                    edge_hit
);

	// The middle row has zero weight, so only top and bottom taps are kept.
	logic [PIX_W-1:0]        top_tap_q [2];
	logic [PIX_W-1:0]        bot_tap_q [2];
	logic [ROW_W-1:0]        top_row, bot_row;
	logic signed [SUM_W-1:0] diff;

	always_comb begin
		top_row  = ROW_W'(top_tap_q[0]) + ROW_W'(top_tap_q[1]) + ROW_W'(top_pix);
		bot_row  = ROW_W'(bot_tap_q[0]) + ROW_W'(bot_tap_q[1]) + ROW_W'(gray);
		diff     = $signed(SUM_W'(bot_row)) - $signed(SUM_W'(top_row));
		sum      = interior ? diff : '0;
		edge_hit = interior && (diff > $signed(SUM_W'(threshold)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_tap_q[0] <= '0;
			top_tap_q[1] <= '0;
			bot_tap_q[0] <= '0;
			bot_tap_q[1] <= '0;
		end else if (adv) begin
			top_tap_q[0] <= top_tap_q[1];
			top_tap_q[1] <= top_pix;
			bot_tap_q[0] <= bot_tap_q[1];
			bot_tap_q[1] <= gray;
		end
	end

endmodule

// File: hw/rtl/gray_prewitt_edge_threshold_top.sv
// Channel   Direction  Handshake              Beat contents
// in        input      in_valid / in_stall    red, green, blue, frame_start
// out       output     out_valid / out_stall  gray_value, edge_valid, edge_value, edge_sum
// cfg       input      cfg_write              cfg_index, cfg_data
//
// One beat per clock sustained while out_stall is low. Stage one registers gray and reads
// both line stores; the output register then captures the kernel sum.
// Each line store has one read and one write port, used once per beat.
// Reset clears position counters, window taps, config and valid flags, but not line stores.
// in_stall rises only when stage one holds a beat and the output register is full and stalled.
module gray_prewitt_edge_threshold_top import gpet_pkg::*; #(
	parameter int MAX_LINE = MAX_LINE_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [PIX_W-1:0]        red,
	input  logic [PIX_W-1:0]        green,
	input  logic [PIX_W-1:0]        blue,
	input  logic                    frame_start,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [PIX_W-1:0]        gray_value,
	output logic                    edge_valid,
	output logic [PIX_W-1:0]        edge_value,
	output logic signed [SUM_W-1:0] edge_sum,
	input  logic                    cfg_write,
	input  logic [1:0]              cfg_index,
	input  logic [CFG_W-1:0]        cfg_data
);

	localparam int CW = $clog2(MAX_LINE);

	logic [THR_W-1:0] thr_q;
	logic [CFG_W-1:0] width_q, height_q;

	logic                       in_accept, s1_adv, s1_move;
	logic [ROW_W-1:0]           rgb_sum;
	logic [ROW_W+RECIP_W-1:0]   gray_prod;
	logic [PIX_W-1:0]           gray_in;
	logic [CW-1:0]              col_in;
	logic                       interior_in;

	logic                       valid_s1;
	logic [PIX_W-1:0]           gray_s1;
	logic [CW-1:0]              col_s1;
	logic                       interior_s1;
	logic [PIX_W-1:0]           upper_s1, middle_s1;
	lb_ctl_t                    lb_ctl;

	logic signed [SUM_W-1:0]    k_sum;
	logic                       k_edge;

	logic                       out_valid_q;
	logic [PIX_W-1:0]           gray_value_q, edge_value_q;
	logic                       edge_valid_q;
	logic signed [SUM_W-1:0]    edge_sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= THR_RESET;
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_EDGE_THRESHOLD: thr_q    <= cfg_data[THR_W-1:0];
				CFG_LINE_PIXELS:    width_q  <= cfg_data;
				CFG_FRAME_LINES:    height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign s1_adv    = !out_valid_q || !out_stall;
	assign s1_move   = valid_s1 && s1_adv;
	assign in_stall  = valid_s1 && !s1_adv;
	assign in_accept = in_valid && !in_stall;

	always_comb begin
		rgb_sum   = ROW_W'(red) + ROW_W'(green) + ROW_W'(blue);
		gray_prod = (ROW_W+RECIP_W)'(rgb_sum) * (ROW_W+RECIP_W)'(GRAY_RECIP);
		gray_in   = gray_prod[GRAY_SHIFT +: PIX_W];
	end

	gpet_pos #(.MAX_LINE(MAX_LINE)) u_pos (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (in_accept),
		.frame_start  (frame_start),
		.line_pixels  (width_q),
		.frame_lines  (height_q),
		.col          (col_in),
		.interior     (interior_in)
	);

	assign lb_ctl.load  = in_accept;
	assign lb_ctl.write = s1_move;

	gpet_linebuf #(.MAX_LINE(MAX_LINE)) u_linebuf (
		.clk       (clk),
		.ctl       (lb_ctl),
		.rd_addr   (col_in),
		.wr_addr   (col_s1),
		.wr_gray   (gray_s1),
		.upper_s1  (upper_s1),
		.middle_s1 (middle_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			gray_s1     <= gray_in;
			col_s1      <= col_in;
			interior_s1 <= interior_in;
		end
	end

	gpet_kernel u_kernel (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (s1_move),
		.interior  (interior_s1),
		.top_pix   (upper_s1),
		.gray      (gray_s1),
		.threshold (thr_q),
		.sum       (k_sum),
		.edge_hit  (k_edge)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			gray_value_q <= gray_s1;
			edge_valid_q <= interior_s1;
			edge_value_q <= k_edge ? EDGE_ON : EDGE_OFF;
			edge_sum_q   <= k_sum;
		end
	end

	assign out_valid  = out_valid_q;
	assign gray_value = gray_value_q;
	assign edge_valid = edge_valid_q;
	assign edge_value = edge_value_q;
	assign edge_sum   = edge_sum_q;

	a_accept_moves_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && valid_s1 |-> s1_adv)
		else $error("input beat accepted while stage one was blocked");

	a_border_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !edge_valid_q |-> edge_sum_q == '0 && edge_value_q == EDGE_OFF)
		else $error("border pixel carries an edge result");

	a_edge_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> edge_value_q == EDGE_ON || edge_value_q == EDGE_OFF)
		else $error("edge value is neither edge nor no edge");

	a_edge_above_thr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && edge_value_q == EDGE_ON |->
			edge_valid_q && edge_sum_q > $signed(SUM_W'(thr_q)))
		else $error("edge reported without the sum exceeding the threshold");

endmodule
